// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the stable insertion sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

    localparam int KEY_W        = 63;
    localparam int TAG_W        = 6;
    localparam int DATA_W       = 72;
    localparam int CAPACITY_DEF = 64;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic             ins;
        logic             shift;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cell_cmd;

endpackage

// ===== src/sts_cell.sv =====
// ----------------------------------------------------------------------------
// sts_cell: one slot of the insertion chain
// Holds one key/tag pair; takes the new pair, the left neighbor's pair on an
// insert, or the right neighbor's pair while the chain drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                      i_clk,
    input  sts_pkg::t_cell_cmd        i_cmd,
    input  logic [CW-1:0]             i_count,
    input  logic                      i_prev_gt,
    input  logic [sts_pkg::KEY_W-1:0] i_prev_key,
    input  logic [sts_pkg::TAG_W-1:0] i_prev_tag,
    input  logic [sts_pkg::KEY_W-1:0] i_next_key,
    input  logic [sts_pkg::TAG_W-1:0] i_next_tag,
    output logic                      o_gt,
    output logic [sts_pkg::KEY_W-1:0] o_key,
    output logic [sts_pkg::TAG_W-1:0] o_tag
);

    logic [sts_pkg::KEY_W-1:0] r_key;
    logic [sts_pkg::TAG_W-1:0] r_tag;
    logic [sts_pkg::KEY_W-1:0] n_key;
    logic [sts_pkg::TAG_W-1:0] n_tag;

    // empty slot or strictly greater key: the new pair goes at or before here
    assign o_gt = (CW'(IDX) >= i_count) || (r_key > i_cmd.key);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_cmd.ins) begin
            if (i_prev_gt) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else if (o_gt) begin
                n_key = i_cmd.key;
                n_tag = i_cmd.tag;
            end
        end else if (i_cmd.shift) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

// ===== src/stable_tagged_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// stable_tagged_insertion_sorter: one insert beat per cycle into a CAPACITY-cell chain.
// Flush: first pair in the cycle after the flush beat, then one per cycle while
// m_axis_tready is high; the input stalls while the chain drains.
// Reset clears the fill count and control only; cell contents are unknown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_tagged_insertion_sorter #(
    parameter int CAPACITY = sts_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sts_pkg::DATA_W-1:0] s_axis_tdata,  // key_value[62:0], tag[68:63], pad
    input  logic                       s_axis_tuser,  // kind
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [sts_pkg::DATA_W-1:0] m_axis_tdata,  // out_key[62:0], out_tag[68:63], pad
    output logic                       m_axis_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PAD_W = sts_pkg::DATA_W - sts_pkg::KEY_W - sts_pkg::TAG_W;

    typedef enum logic {ST_IDLE, ST_DRAIN} t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic               w_in_beat;
    logic               w_out_beat;
    logic               w_full;
    sts_pkg::t_cell_cmd w_cmd;

    logic                      w_gt  [CAPACITY];
    logic [sts_pkg::KEY_W-1:0] w_key [CAPACITY];
    logic [sts_pkg::TAG_W-1:0] w_tag [CAPACITY];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_beat    = m_axis_tvalid && m_axis_tready;
    assign w_full        = (r_count == CW'(CAPACITY));

    assign w_cmd.ins   = w_in_beat && (s_axis_tuser == sts_pkg::KIND_INSERT) && !w_full;
    assign w_cmd.shift = w_out_beat;
    assign w_cmd.key   = s_axis_tdata[sts_pkg::KEY_W-1:0];
    assign w_cmd.tag   = s_axis_tdata[sts_pkg::KEY_W +: sts_pkg::TAG_W];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      w_prev_gt;
        logic [sts_pkg::KEY_W-1:0] w_prev_key;
        logic [sts_pkg::TAG_W-1:0] w_prev_tag;
        logic [sts_pkg::KEY_W-1:0] w_next_key;
        logic [sts_pkg::TAG_W-1:0] w_next_tag;

        if (i == 0) begin : g_head
            assign w_prev_gt  = 1'b0;
            assign w_prev_key = w_cmd.key;
            assign w_prev_tag = w_cmd.tag;
        end else begin : g_body
            assign w_prev_gt  = w_gt[i-1];
            assign w_prev_key = w_key[i-1];
            assign w_prev_tag = w_tag[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_key = w_key[i];
            assign w_next_tag = w_tag[i];
        end else begin : g_link
            assign w_next_key = w_key[i+1];
            assign w_next_tag = w_tag[i+1];
        end

        sts_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_count    (r_count),
            .i_prev_gt  (w_prev_gt),
            .i_prev_key (w_prev_key),
            .i_prev_tag (w_prev_tag),
            .i_next_key (w_next_key),
            .i_next_tag (w_next_tag),
            .o_gt       (w_gt[i]),
            .o_key      (w_key[i]),
            .o_tag      (w_tag[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_cmd.ins) begin
                        r_count <= r_count + CW'(1);
                    end else if (w_in_beat && (s_axis_tuser == sts_pkg::KIND_FLUSH)
                                 && (r_count != '0)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_out_beat) begin
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == ST_DRAIN);
    assign m_axis_tlast  = (r_count == CW'(1));
    assign m_axis_tdata  = {{PAD_W{1'b0}}, w_tag[0], w_key[0]};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_count != '0))
        else $error("output beat with empty store");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the store");

    a_flush_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && (s_axis_tuser == sts_pkg::KIND_FLUSH) && (r_count != '0))
        |=> m_axis_tvalid)
        else $error("flush of a filled store produced no beat");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_beat && m_axis_tlast) |=> (!m_axis_tvalid && (r_count == '0)))
        else $error("drain continued after last beat");

endmodule

// ===== bench/sts_order_checker.sv =====
// ----------------------------------------------------------------------------
// sts_order_checker: scoreboard for the stable tagged insertion sorter
// Watches both stream channels, keeps its own sorted store of the accepted
// insert beats and, on each flush beat, queues the pairs it should emit.
// Every output beat is compared field by field with the oldest queued pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_order_checker #(
    parameter int CAPACITY = sts_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    input  logic                       i_s_ready,
    input  logic [sts_pkg::DATA_W-1:0] i_s_data,   // key_value[62:0], tag[68:63], pad
    input  logic                       i_s_kind,
    input  logic                       i_m_valid,
    input  logic                       i_m_ready,
    input  logic [sts_pkg::DATA_W-1:0] i_m_data,   // out_key[62:0], out_tag[68:63], pad
    input  logic                       i_m_last,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int PAD_W = sts_pkg::DATA_W - sts_pkg::KEY_W - sts_pkg::TAG_W;
    localparam int KT_W  = sts_pkg::KEY_W + sts_pkg::TAG_W;

    typedef logic [sts_pkg::DATA_W-1:0] t_beat_data;

    typedef struct packed {
        logic [sts_pkg::KEY_W-1:0] key;
        logic [sts_pkg::TAG_W-1:0] tag;
        logic                      last;
    } t_sorted_pair;

    logic [sts_pkg::KEY_W-1:0] stored_keys [CAPACITY];
    logic [sts_pkg::TAG_W-1:0] stored_tags [CAPACITY];
    int                        held_count;
    t_sorted_pair              due_pairs [$];
    int                        fail_count;

    initial begin
        fail_count   = 0;
        held_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input t_beat_data got,
                                   input t_beat_data want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic place_pair(input logic [sts_pkg::KEY_W-1:0] key,
                              input logic [sts_pkg::TAG_W-1:0] tag);
        int pos;
        // drop inserts into a full store
        if (held_count >= CAPACITY) begin
            return;
        end
        pos = held_count;
        // equal keys stay ahead of the newcomer
        while (pos > 0 && stored_keys[pos-1] > key) begin
            stored_keys[pos] = stored_keys[pos-1];
            stored_tags[pos] = stored_tags[pos-1];
            pos--;
        end
        stored_keys[pos] = key;
        stored_tags[pos] = tag;
        held_count++;
    endtask

    task automatic queue_flush();
        t_sorted_pair pair;
        for (int k = 0; k < held_count; k++) begin
            pair.key  = stored_keys[k];
            pair.tag  = stored_tags[k];
            pair.last = (k == held_count - 1);
            due_pairs.push_back(pair);
        end
        held_count = 0;
    endtask

    task automatic check_out_beat();
        t_sorted_pair want;
        if (due_pairs.size() == 0) begin
            report_mismatch("unexpected output beat", i_m_data, '0);
            return;
        end
        want = due_pairs.pop_front();
        if (i_m_data[sts_pkg::KEY_W-1:0] !== want.key) begin
            report_mismatch("out_key", t_beat_data'(i_m_data[sts_pkg::KEY_W-1:0]),
                            t_beat_data'(want.key));
        end
        if (i_m_data[KT_W-1:sts_pkg::KEY_W] !== want.tag) begin
            report_mismatch("out_tag", t_beat_data'(i_m_data[KT_W-1:sts_pkg::KEY_W]),
                            t_beat_data'(want.tag));
        end
        if (i_m_data[sts_pkg::DATA_W-1:KT_W] !== {PAD_W{1'b0}}) begin
            report_mismatch("tdata pad", t_beat_data'(i_m_data[sts_pkg::DATA_W-1:KT_W]),
                            '0);
        end
        if (i_m_last !== want.last) begin
            report_mismatch("tlast", t_beat_data'(i_m_last), t_beat_data'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            due_pairs.delete();
        end else begin
            // pairs on the output belong to an earlier flush: check them first
            if (i_m_valid && i_m_ready) begin
                check_out_beat();
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_kind == sts_pkg::KIND_FLUSH) begin
                    queue_flush();
                end else begin
                    place_pair(i_s_data[sts_pkg::KEY_W-1:0], i_s_data[KT_W-1:sts_pkg::KEY_W]);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_pairs.size();
    end

endmodule

// ===== bench/stable_tagged_insertion_sorter_tb.sv =====
// ----------------------------------------------------------------------------
// stable_tagged_insertion_sorter_tb: stimulus and verdict for the sorter
// Drives insert and flush beats with random gaps and output stalls: a short
// directed set of extremes, equal keys and empty flushes, then random runs
// of inserts closed by a flush, some of them overfilling the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_tagged_insertion_sorter_tb;

    typedef logic [sts_pkg::KEY_W-1:0] t_key;
    typedef logic [sts_pkg::TAG_W-1:0] t_tag;

    localparam int   CAPACITY  = sts_pkg::CAPACITY_DEF;
    localparam int   ITEM_GOAL = 215;
    localparam int   PAD_W     = sts_pkg::DATA_W - sts_pkg::KEY_W - sts_pkg::TAG_W;
    localparam t_key KEY_MAX   = {sts_pkg::KEY_W{1'b1}};

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [sts_pkg::DATA_W-1:0] s_axis_tdata;    // key_value[62:0], tag[68:63], pad
    logic                       s_axis_tuser;    // kind
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [sts_pkg::DATA_W-1:0] m_axis_tdata;    // out_key[62:0], out_tag[68:63], pad
    logic                       m_axis_tlast;

    int                fail_count;
    int                pending_pairs;
    int                beats_sent;
    bit                calm;

    stable_tagged_insertion_sorter #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sts_order_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_kind     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_last     (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_pairs)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #(20_000_000);
        $display("stable_tagged_insertion_sorter verification failed");
        $finish;
    end

    function automatic t_key pick_key(input bit crowded);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (crowded) begin
            return t_key'($urandom_range(0, 7));
        end
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return KEY_MAX;
            2:       return KEY_MAX - t_key'($urandom_range(0, 3));
            3:       return t_key'(raw[15:0]);
            default: return raw[sts_pkg::KEY_W-1:0];
        endcase
    endfunction

    // enter just after a rising edge; leave just after the edge that takes the beat
    task automatic send_beat(input logic kind, input t_key key, input t_tag tag);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{PAD_W{1'b0}}, tag, key};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_pairs != 0);
    endtask

    // output side: stall a random number of cycles before each beat
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
        end
    end

    initial begin
        int  run;
        int  run_len;
        bit  crowded;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = sts_pkg::KIND_INSERT;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        beats_sent    = 0;
        calm          = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // flush an empty store, with junk in the ignored fields
        send_beat(sts_pkg::KIND_FLUSH, KEY_MAX, '1);
        send_beat(sts_pkg::KIND_INSERT, KEY_MAX, 6'd63);
        send_beat(sts_pkg::KIND_INSERT, '0, 6'd0);
        send_beat(sts_pkg::KIND_INSERT, 63'd5, 6'd1);
        send_beat(sts_pkg::KIND_INSERT, 63'd5, 6'd2);
        send_beat(sts_pkg::KIND_INSERT, 63'd5, 6'd3);
        send_beat(sts_pkg::KIND_INSERT, 63'd3, 6'd4);
        send_beat(sts_pkg::KIND_INSERT, KEY_MAX, 6'd5);
        send_beat(sts_pkg::KIND_FLUSH, '0, '0);
        send_beat(sts_pkg::KIND_FLUSH, 63'h2AAA_AAAA_AAAA_AAAA, 6'h2A);
        for (int k = 0; k < 4; k++) begin
            send_beat(sts_pkg::KIND_INSERT, KEY_MAX - t_key'(k * 1000), t_tag'(10 + k));
        end
        send_beat(sts_pkg::KIND_FLUSH, 63'h5555_5555_5555_5555, 6'h15);
        for (int k = 0; k < 3; k++) begin
            send_beat(sts_pkg::KIND_INSERT, t_key'(k) << (20 * k), t_tag'(20 + k));
        end
        send_beat(sts_pkg::KIND_FLUSH, '0, '0);

        run = 0;
        while (beats_sent < ITEM_GOAL) begin
            calm    = ($urandom_range(0, 4) == 0);
            crowded = ($urandom_range(0, 1) == 1);
            // overfill the store now and then, always once early on
            if (run == 1 || $urandom_range(0, 11) == 0) begin
                run_len = CAPACITY + int'($urandom_range(1, 4));
            end else begin
                run_len = int'($urandom_range(0, 12));
            end
            for (int k = 0; k < run_len; k++) begin
                send_beat(sts_pkg::KIND_INSERT, pick_key(crowded),
                          t_tag'($urandom_range(0, 63)));
            end
            send_beat(sts_pkg::KIND_FLUSH, pick_key(1'b0), t_tag'($urandom_range(0, 63)));
            // hold off until the store has drained completely
            if (run == 1 || run == 3) begin
                drain_results();
            end
            run++;
        end
        calm = 1'b0;
        send_beat(sts_pkg::KIND_FLUSH, '0, '0);

        drain_results();
        repeat (CAPACITY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stable_tagged_insertion_sorter verification clean");
        end else begin
            $display("stable_tagged_insertion_sorter verification failed");
        end
        $finish;
    end

endmodule
